/* hdl/dpp_pkg.sv */
// Shared types, widths and register codes for the depth pixel back-projection pipeline.
`timescale 1ns / 1ps
`default_nettype none
package dpp_pkg;

  // Pipeline depth: each stage carries its own valid bit
  localparam int NumStages = 5;

  // Field widths
  localparam int DepthW  = 16;
  localparam int CoordW  = 12;
  localparam int ScaleW  = 32;
  localparam int RecipW  = 24;
  localparam int CenterW = 16;
  localparam int FwdW    = 20;
  localparam int LatW    = 21;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  // Internal arithmetic widths
  localparam int CoordFracW = 4;
  localparam int DiffW   = CoordW + CoordFracW + 1;
  localparam int MagW    = DiffW - 1;
  localparam int ZProdW  = DepthW + ScaleW;
  localparam int ZW      = 32;
  localparam int ZHalfW  = ZW / 2;
  localparam int AW      = MagW + RecipW;
  localparam int PartW   = AW + ZHalfW;
  localparam int SumW    = PartW + 1;
  localparam int LoW     = SumW - ZHalfW;
  localparam int FinalShift = 12;
  localparam int MagOutW = SumW - FinalShift;

  // Rounding constants and saturation limits
  localparam logic [ZProdW:0]  ZRound   = (ZProdW + 1)'(32768);
  localparam logic [SumW-1:0]  LatRound = SumW'(64'd1 << 27);
  localparam logic [FwdW-1:0]  FwdMax   = {FwdW{1'b1}};
  localparam logic [LatW-1:0]  LatPosMax = {1'b0, {(LatW - 1){1'b1}}};
  localparam logic [LatW-1:0]  LatNegMag = {1'b1, {(LatW - 1){1'b0}}};

  typedef logic [NumStages-1:0] stage_en_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDepthScale = 3'd0,
    CfgRecipX     = 3'd1,
    CfgRecipY     = 3'd2,
    CfgCenterX    = 3'd3,
    CfgCenterY    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [ScaleW-1:0]  depth_scale;
    logic [RecipW-1:0]  recip_x;
    logic [RecipW-1:0]  recip_y;
    logic [CenterW-1:0] center_x;
    logic [CenterW-1:0] center_y;
  } cfg_t;

endpackage
`default_nettype wire

/* hdl/dpp_cfg.sv */
// Configuration register file for the camera intrinsics and depth scale.
`timescale 1ns / 1ps
`default_nettype none
module dpp_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [dpp_pkg::CfgIdxW-1:0]   idx_i,
  input  logic [dpp_pkg::CfgDataW-1:0]  data_i,
  output dpp_pkg::cfg_t                 cfg_o
);
  import dpp_pkg::*;

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (cfg_idx_e'(idx_i))
        CfgDepthScale: cfg_d.depth_scale = data_i[ScaleW-1:0];
        CfgRecipX:     cfg_d.recip_x     = data_i[RecipW-1:0];
        CfgRecipY:     cfg_d.recip_y     = data_i[RecipW-1:0];
        CfgCenterX:    cfg_d.center_x    = data_i[CenterW-1:0];
        CfgCenterY:    cfg_d.center_y    = data_i[CenterW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.depth_scale <= ScaleW'(6554);
      cfg_q.recip_x     <= RecipW'(27962);
      cfg_q.recip_y     <= RecipW'(27962);
      cfg_q.center_x    <= CenterW'(5120);
      cfg_q.center_y    <= CenterW'(3840);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

/* hdl/dpp_lane.sv */
// One lateral axis: offset from center, reciprocal scaling, depth product, rounding, saturation.
`timescale 1ns / 1ps
`default_nettype none
module dpp_lane (
  input  logic                               clk_i,
  input  dpp_pkg::stage_en_t                 en_i,
  input  logic [dpp_pkg::CoordW-1:0]         coord_i,
  input  logic [dpp_pkg::CenterW-1:0]        center_i,
  input  logic [dpp_pkg::RecipW-1:0]         recip_i,
  input  logic [dpp_pkg::ZW-1:0]             z_i,
  output logic signed [dpp_pkg::LatW-1:0]    lat_o
);
  import dpp_pkg::*;

  // Stage 1: signed offset in Q4, split into sign and magnitude
  logic [DiffW-1:0] diff, diff_neg;
  logic             sgn1_d, sgn1_q;
  logic [MagW-1:0]  mag1_d, mag1_q;

  assign diff     = {1'b0, coord_i, {CoordFracW{1'b0}}} - {1'b0, center_i};
  assign diff_neg = DiffW'(0) - diff;
  assign sgn1_d   = diff[DiffW-1];
  assign mag1_d   = sgn1_d ? diff_neg[MagW-1:0] : diff[MagW-1:0];

  // Stage 2: magnitude times focal reciprocal
  logic          sgn2_q;
  logic [AW-1:0] a2_d, a2_q;
  assign a2_d = AW'(mag1_q) * AW'(recip_i);

  // Stage 3: two partial products against the depth halves
  logic             sgn3_q;
  logic [PartW-1:0] plo3_d, plo3_q, phi3_d, phi3_q;
  assign plo3_d = PartW'(a2_q) * PartW'(z_i[ZHalfW-1:0]);
  assign phi3_d = PartW'(a2_q) * PartW'(z_i[ZW-1:ZHalfW]);

  // Stage 4: round the low partial product
  logic             sgn4_q;
  logic [SumW-1:0]  lo_sum;
  logic [LoW-1:0]   lo4_d, lo4_q;
  logic [PartW-1:0] phi4_q;
  assign lo_sum = {1'b0, plo3_q} + LatRound;
  assign lo4_d  = lo_sum[SumW-1:ZHalfW];

  // Stage 5: combine, drop the fraction, saturate and negate for output axes
  logic [SumW-1:0]    hi_sum;
  logic [MagOutW-1:0] mag5;
  logic [LatW-1:0]    pos_cap, neg_cap, lat_d, lat_q;
  assign hi_sum  = {1'b0, phi4_q} + SumW'(lo4_q);
  assign mag5    = hi_sum[SumW-1:FinalShift];
  assign pos_cap = (mag5 > MagOutW'(LatPosMax)) ? LatPosMax : mag5[LatW-1:0];
  assign neg_cap = (mag5 > MagOutW'(LatNegMag)) ? LatNegMag : mag5[LatW-1:0];
  // negative offset means negative x, so the output axis is positive
  assign lat_d   = sgn4_q ? pos_cap : (LatW'(0) - neg_cap);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sgn1_q <= sgn1_d;
      mag1_q <= mag1_d;
    end
    if (en_i[1]) begin
      sgn2_q <= sgn1_q;
      a2_q   <= a2_d;
    end
    if (en_i[2]) begin
      sgn3_q <= sgn2_q;
      plo3_q <= plo3_d;
      phi3_q <= phi3_d;
    end
    if (en_i[3]) begin
      sgn4_q <= sgn3_q;
      lo4_q  <= lo4_d;
      phi4_q <= phi3_q;
    end
    if (en_i[4]) begin
      lat_q <= lat_d;
    end
  end

  assign lat_o = lat_q;

endmodule
`default_nettype wire

/* hdl/depth_pixel_to_point.sv */
// Top level: depth pixel to 3-D point back-projection pipeline with handshake control.
//
// channel   direction  handshake                  payload
// in        sink       in_valid_i / in_ready_o    depth_code_i, pixel_col_i, pixel_row_i
// out       source     out_valid_o / out_ready_i  forward_centi_o, left_centi_o, up_centi_o
// cfg       sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// Five register stages, one point per cycle while the output is not stalled.
// The stages per axis are the offset from center, the reciprocal multiply,
// the two partial products against depth side by side, and the two rounding adds.
// Pixels with zero depth are dropped in the first stage and leave a bubble that later items fill.
// Each stage holds while the one after it is full and stalled; no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module depth_pixel_to_point (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [dpp_pkg::DepthW-1:0]         depth_code_i,
  input  logic [dpp_pkg::CoordW-1:0]         pixel_col_i,
  input  logic [dpp_pkg::CoordW-1:0]         pixel_row_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [dpp_pkg::FwdW-1:0]           forward_centi_o,
  output logic signed [dpp_pkg::LatW-1:0]    left_centi_o,
  output logic signed [dpp_pkg::LatW-1:0]    up_centi_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dpp_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [dpp_pkg::CfgDataW-1:0]       cfg_data_i
);
  import dpp_pkg::*;

  cfg_t      cfg;
  stage_en_t en;
  logic [NumStages-1:0] v_d, v_q;

  assign cfg_ready_o = 1'b1;

  dpp_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_valid_i && cfg_ready_o),
    .idx_i  (cfg_index_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  // A stage loads when it is empty or the stage after it moves on
  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_comb begin
    v_d = v_q;
    if (en[0]) v_d[0] = in_valid_i && (depth_code_i != '0);
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) v_d[k] = v_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // Depth path: scale, round, saturate
  logic [ZProdW-1:0] pz1_d, pz1_q;
  logic [ZProdW:0]   z_sum;
  logic [ZW-1:0]     z2_d, z2_q;
  logic [FwdW-1:0]   fwd3_d, fwd3_q, fwd4_q, fwd5_q;

  assign pz1_d  = ZProdW'(depth_code_i) * ZProdW'(cfg.depth_scale);
  assign z_sum  = {1'b0, pz1_q} + ZRound;
  assign z2_d   = z_sum[ZW+ZHalfW-1:ZHalfW];
  assign fwd3_d = (z2_q > ZW'(FwdMax)) ? FwdMax : z2_q[FwdW-1:0];

  always_ff @(posedge clk_i) begin
    if (en[0]) pz1_q  <= pz1_d;
    if (en[1]) z2_q   <= z2_d;
    if (en[2]) fwd3_q <= fwd3_d;
    if (en[3]) fwd4_q <= fwd3_q;
    if (en[4]) fwd5_q <= fwd4_q;
  end

  dpp_lane u_lane_x (
    .clk_i    (clk_i),
    .en_i     (en),
    .coord_i  (pixel_col_i),
    .center_i (cfg.center_x),
    .recip_i  (cfg.recip_x),
    .z_i      (z2_q),
    .lat_o    (left_centi_o)
  );

  dpp_lane u_lane_y (
    .clk_i    (clk_i),
    .en_i     (en),
    .coord_i  (pixel_row_i),
    .center_i (cfg.center_y),
    .recip_i  (cfg.recip_y),
    .z_i      (z2_q),
    .lat_o    (up_centi_o)
  );

  assign out_valid_o     = v_q[NumStages-1];
  assign forward_centi_o = fwd5_q;

  // A zero-depth transaction never occupies the first stage
  a_zero_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (depth_code_i == '0) |=> !v_q[0])
    else $error("zero-depth pixel entered the pipeline");

  // A held middle stage keeps its item
  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[2] && !en[2] |=> v_q[2])
    else $error("stalled stage lost its item");

  // An empty output stage lets the whole pipeline advance
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[NumStages-1] |-> in_ready_o)
    else $error("input stalled with empty output stage");

  // A full pipeline under output stall refuses input
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q == {NumStages{1'b1}}) && !out_ready_i |-> !in_ready_o)
    else $error("input taken while every stage is held");

endmodule
`default_nettype wire
